// ===== rtl/pts_pkg.sv =====
// Package for the polynomial Taylor shift block: sizes, item structs,
// microcode control word and the microprogram ROM. No dependencies.
package pts_pkg;

   localparam int MAX_DEGREE = 15;
   localparam int DEPTH      = MAX_DEGREE + 1;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int POS_W      = 4;
   localparam int UPC_W      = 3;

   typedef struct packed {
      logic signed [DATA_W-1:0] coefficient_in;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] coefficient_out;
      logic [POS_W-1:0]         position_out;
      logic                     last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_PASS_INIT,
      OP_MUL,
      OP_ADD,
      OP_PASS_END,
      OP_EMIT_INIT,
      OP_EMIT,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_RUN,
      C_LIM_ZERO,
      C_MORE,
      C_NOT_END
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
   } ctrl_type;

   typedef struct packed {
      logic launch;
      logic lim_zero;
      logic more;
      logic not_end;
   } status_type;

   // Microprogram: branch to target when cond holds, else fall through.
   function automatic ctrl_type rom_word(input logic [UPC_W-1:0] upc);
      ctrl_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: UPC_W'(0)};
      case (upc)
         3'd0: w = '{op: OP_WAIT,      cond: C_NO_RUN,   target: UPC_W'(0)};
         3'd1: w = '{op: OP_PASS_INIT, cond: C_LIM_ZERO, target: UPC_W'(5)};
         3'd2: w = '{op: OP_MUL,       cond: C_NEVER,    target: UPC_W'(0)};
         3'd3: w = '{op: OP_ADD,       cond: C_MORE,     target: UPC_W'(2)};
         3'd4: w = '{op: OP_PASS_END,  cond: C_ALWAYS,   target: UPC_W'(1)};
         3'd5: w = '{op: OP_EMIT_INIT, cond: C_NEVER,    target: UPC_W'(0)};
         3'd6: w = '{op: OP_EMIT,      cond: C_NOT_END,  target: UPC_W'(6)};
         default: w = '{op: OP_NOP,    cond: C_ALWAYS,   target: UPC_W'(0)};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/pts_sequencer.sv =====
// Microcode sequencer: step counter, program ROM lookup and branch logic.
// Depends on pts_pkg.
module pts_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  pts_pkg::status_type status,
   output pts_pkg::ctrl_type   ctrl
);
   import pts_pkg::*;

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic             taken;

   assign ctrl = rom_word(upc_ff);

   always_comb begin
      case (ctrl.cond)
         C_NEVER:    taken = 1'b0;
         C_ALWAYS:   taken = 1'b1;
         C_NO_RUN:   taken = !status.launch;
         C_LIM_ZERO: taken = status.lim_zero;
         C_MORE:     taken = status.more;
         C_NOT_END:  taken = status.not_end;
         default:    taken = 1'b0;
      endcase
      upc_in = taken ? ctrl.target : upc_ff + UPC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= '0;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== rtl/pts_datapath.sv =====
// Datapath: coefficient store, shift register, multiplier, saturating adder,
// loop indexes and result register. Driven by pts_sequencer; uses pts_pkg.
module pts_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pts_pkg::ctrl_type   ctrl,
   input  logic                start,
   input  pts_pkg::req_type    req,
   input  logic                csr_we,
   input  logic [31:0]         csr_wdata,
   output pts_pkg::status_type status,
   output logic                rsp_strobe,
   output pts_pkg::rsp_type    rsp
);
   import pts_pkg::*;

   localparam logic signed [48:0] SAT_MAX = 49'sd2147483647;
   localparam logic signed [48:0] SAT_MIN = -49'sd2147483648;

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] shift_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         n_ff, n_in;
   logic [IDX_W-1:0]         lim_ff, lim_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     accept;
   logic                     full;
   logic [IDX_W-1:0]         launch_idx;
   logic signed [48:0]       sum;
   logic signed [DATA_W-1:0] sat;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   assign accept     = start && (ctrl.op == OP_WAIT);
   assign full       = count_ff >= CNT_W'(DEPTH);
   assign launch_idx = full ? IDX_W'(MAX_DEGREE) : count_ff[IDX_W-1:0];

   assign sum = 49'(cur_ff) + 49'(prod_ff >>> 16);
   always_comb begin
      if (sum > SAT_MAX) begin
         sat = DATA_W'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         sat = DATA_W'(SAT_MIN);
      end else begin
         sat = DATA_W'(sum);
      end
   end

   always_comb begin
      count_in      = count_ff;
      n_in          = n_ff;
      lim_in        = lim_ff;
      i_in          = i_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      prod_in       = prod_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = i_ff;
      wr_data       = sat;
      case (ctrl.op)
         OP_WAIT: begin
            if (accept && req.last_in) begin
               n_in     = launch_idx;
               lim_in   = launch_idx;
               count_in = '0;
               wr_en    = 1'b1;
               wr_addr  = launch_idx;
               wr_data  = req.coefficient_in;
            end else if (accept && !full) begin
               count_in = count_ff + CNT_W'(1);
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_data  = req.coefficient_in;
            end
         end
         OP_PASS_INIT: begin
            i_in    = IDX_W'(1);
            prev_in = store_ff[0];
         end
         OP_MUL: begin
            prod_in = shift_ff * prev_ff;
            cur_in  = store_ff[i_ff];
         end
         OP_ADD: begin
            wr_en   = 1'b1;
            prev_in = sat;
            i_in    = i_ff + IDX_W'(1);
         end
         OP_PASS_END: begin
            lim_in = lim_ff - IDX_W'(1);
         end
         OP_EMIT_INIT: begin
            i_in = '0;
         end
         OP_EMIT: begin
            rsp_strobe_in          = 1'b1;
            rsp_in.coefficient_out = store_ff[i_ff];
            rsp_in.position_out    = POS_W'(i_ff);
            rsp_in.last_out        = (i_ff == n_ff);
            i_in                   = i_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign status.launch   = accept && req.last_in;
   assign status.lim_zero = (lim_ff == '0);
   assign status.more     = (i_ff != lim_ff);
   assign status.not_end  = (i_ff != n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         count_ff      <= '0;
         n_ff          <= '0;
         lim_ff        <= '0;
         i_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            shift_ff <= csr_wdata;
         end
         count_ff      <= count_in;
         n_ff          <= n_in;
         lim_ff        <= lim_in;
         i_ff          <= i_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ===== rtl/polynomial_taylor_shift.sv =====
// Top level of the polynomial Taylor shift block (repeated Horner).
// Instantiates pts_sequencer and pts_datapath; uses pts_pkg.
//
// Usage:
// - Input: present an item on req_data and raise start; it is taken at a clock
//   edge where start is high and busy is low. Items carry coefficients
//   highest degree first; the item with last_in set is the constant term.
// - Loading: one item per cycle, busy stays low. Items beyond 16 without
//   last_in are dropped; a last item then replaces the final entry.
// - Run: the last item starts the microprogram and raises busy. With degree
//   n it makes n passes, each a setup step, a multiply and an add step on the
//   shared multiplier and adder per coefficient it updates, and an end step;
//   a last setup step, an emit setup step, an emit step per item and a return follow.
// - Output: n+1 items on rsp_data, one per cycle, each shown for one cycle
//   with rsp_strobe high, highest degree first, last_out on the constant term.
//   The receiver cannot stall; results must be taken as shown.
// - Config: csr_we with csr_wdata sets the shift value c (Q16.16) while idle.
// - Reset (synchronous): c = 0, store empty, sequencer idle, no results.
module polynomial_taylor_shift (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pts_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   output logic             rsp_strobe,
   output pts_pkg::rsp_type rsp_data
);
   import pts_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   pts_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   pts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .start      (start),
      .req        (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

   assign busy = (ctrl.op != OP_WAIT);

endmodule
